// ===== hw/rtl/msta_pkg.sv =====
`timescale 1ns / 1ps
// msta_pkg: shared types, constants and the hex digit decoder for the
// motor speed telemetry averager. No dependencies.
package msta_pkg;

  localparam int unsigned RPM_W       = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Marker "2A02" that precedes the speed word in a reply line
  localparam logic [7:0] MARKER [4] = '{8'h32, 8'h41, 8'h30, 8'h32};
  localparam logic [2:0] MARKER_LEN = 3'd4;

  localparam logic [7:0] NEWLINE    = 8'd10;
  localparam logic [3:0] LINE_LEN   = 4'd12;  // chars after marker that close a sample
  localparam logic [3:0] HEX_DIGITS = 4'd8;

  localparam logic [15:0] CUTOFF_RESET = 16'd10000;

  // rpm = floor(mag*6/10000). Any mag at or above this gives rpm > 65535,
  // which is above every cutoff value.
  localparam logic [31:0] RPM_BIG_MAG = 32'd109226667;
  // floor(x/10000) for x < 2^30 as (x * ceil(2^44/10000)) >> 44
  localparam logic [30:0] RPM_RECIP = 31'd1759218605;
  localparam int unsigned RPM_SHIFT = 44;

  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } sample_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/msta_intf.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the telemetry averager: characters in,
// averaged speed out, cutoff register writes. No dependencies.
interface msta_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_char;
  modport source (output valid, output rx_char, input ready);
  modport sink (input valid, input rx_char, output ready);
endinterface

interface msta_speed_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] avg_speed;
  modport source (output valid, output avg_speed, input ready);
  modport sink (input valid, input avg_speed, output ready);
endinterface

interface msta_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_cutoff;
  modport source (output valid, output speed_cutoff, input ready);
  modport sink (input valid, input speed_cutoff, output ready);
endinterface

// ===== hw/rtl/msta_front.sv =====
`timescale 1ns / 1ps
// msta_front: line parser. Finds the marker, gathers the 8 hex digits and
// emits the raw 32-bit word at the 12th character. Depends on msta_pkg.
module msta_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_char_i,
  output msta_pkg::sample_t     sample_o
);

  logic [2:0]  mp_q, mp_d;
  logic        found_q, found_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] word_q, word_d;
  logic        bad_q, bad_d;
  logic        emit;

  always_comb begin
    logic [3:0] n;
    logic [2:0] pos;
    logic [2:0] nib;
    logic [2:0] mp_nx;
    logic [4:0] hx;
    mp_d    = mp_q;
    found_d = found_q;
    cnt_d   = cnt_q;
    word_d  = word_q;
    bad_d   = bad_q;
    emit    = 1'b0;
    n       = cnt_q + 4'd1;
    pos     = 3'(n - 4'd1);
    nib     = {pos[2:1], ~pos[0]};  // little-endian bytes, high nibble first
    hx      = msta_pkg::hex_decode(rx_char_i);
    mp_nx   = 3'd0;
    if (accept_i) begin
      if (found_q) begin
        if (cnt_q < msta_pkg::LINE_LEN) begin
          cnt_d = n;
          if (n <= msta_pkg::HEX_DIGITS) begin
            if (!hx[4]) begin
              bad_d = 1'b1;
            end else begin
              word_d = word_q | (32'(hx[3:0]) << {nib, 2'b00});
            end
          end
          if (n == msta_pkg::LINE_LEN && !bad_q) begin
            emit = 1'b1;
          end
        end
      end else begin
        if (rx_char_i == msta_pkg::MARKER[mp_q[1:0]]) begin
          mp_nx = mp_q + 3'd1;
        end else if (rx_char_i == msta_pkg::MARKER[0]) begin
          mp_nx = 3'd1;
        end else begin
          mp_nx = 3'd0;
        end
        if (mp_nx == msta_pkg::MARKER_LEN) begin
          mp_d    = 3'd0;
          found_d = 1'b1;
          cnt_d   = 4'd0;
          word_d  = 32'd0;
          bad_d   = 1'b0;
        end else begin
          mp_d = mp_nx;
        end
      end
      if (rx_char_i == msta_pkg::NEWLINE) begin
        mp_d    = 3'd0;
        found_d = 1'b0;
        cnt_d   = 4'd0;
        word_d  = 32'd0;
        bad_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q    <= 3'd0;
      found_q <= 1'b0;
      cnt_q   <= 4'd0;
      word_q  <= 32'd0;
      bad_q   <= 1'b0;
    end else begin
      mp_q    <= mp_d;
      found_q <= found_d;
      cnt_q   <= cnt_d;
      word_q  <= word_d;
      bad_q   <= bad_d;
    end
  end

  // word is complete by the 8th digit, so the held value is final here
  assign sample_o.valid = emit;
  assign sample_o.word  = word_q;

endmodule

// ===== hw/rtl/msta_fifo.sv =====
`timescale 1ns / 1ps
// msta_fifo: small register FIFO that decouples the parser from the
// arithmetic pipeline. No dependencies.
module msta_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hw/rtl/msta_back.sv =====
`timescale 1ns / 1ps
// msta_back: sign/magnitude, rpm scaling, cutoff, moving-average window and
// output register. Depends on msta_pkg and msta_speed_if.
module msta_back #(
  parameter int unsigned WINDOW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msta_pkg::sample_t  head_i,
  output logic               pop_o,
  input  logic [15:0]        cutoff_i,
  msta_speed_if.source       speed_o
);

  localparam int unsigned SUM_W   = $clog2(WINDOW * 65535 + 1);
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam logic [63:0] RECIP64 = ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam int unsigned RW      = msta_pkg::RPM_W;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic neg1_q, neg2_q, neg3_q, neg4_q;
  logic big1_q, big2_q;
  logic [29:0] x1_q;
  logic [60:0] prod2_q;
  logic [PROD_W-1:0] prod4_q;
  logic [16:0] avg_q;
  logic [RW-1:0] hist_q [WINDOW];
  logic [SUM_W-1:0] sum_q;

  logic [31:0] mag;
  logic [29:0] x_d;
  logic [RW-1:0] rpm_raw, rpm;
  logic [RW-1:0] avg_mag;

  // whole pipeline advances together whenever the output slot can take data
  assign en    = !out_valid_q || speed_o.ready;
  assign pop_o = head_i.valid && en;

  // stage 1: magnitude and times six
  assign mag = head_i.word[31] ? (32'd0 - head_i.word) : head_i.word;
  assign x_d = {1'b0, mag[26:0], 2'b00} + {2'b00, mag[26:0], 1'b0};

  // stage 3: rpm and cutoff
  assign rpm_raw = prod2_q[msta_pkg::RPM_SHIFT +: RW];
  assign rpm     = (big2_q || rpm_raw > cutoff_i) ? '0 : rpm_raw;

  // stage 5: sum / WINDOW
  assign avg_mag = prod4_q[SHIFT +: RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        hist_q[i] <= '0;
      end
    end else if (en) begin
      v1_q        <= head_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
      if (v2_q) begin
        sum_q     <= sum_q - SUM_W'(hist_q[WINDOW-1]) + SUM_W'(rpm);
        hist_q[0] <= rpm;
        for (int i = 1; i < WINDOW; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q  <= head_i.word[31];
      big1_q  <= (mag >= msta_pkg::RPM_BIG_MAG);
      x1_q    <= x_d;
      neg2_q  <= neg1_q;
      big2_q  <= big1_q;
      prod2_q <= 61'(x1_q) * 61'(msta_pkg::RPM_RECIP);
      neg3_q  <= neg2_q;
      neg4_q  <= neg3_q;
      prod4_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
      avg_q   <= neg4_q ? (17'd0 - {1'b0, avg_mag}) : {1'b0, avg_mag};
    end
  end

  assign speed_o.valid     = out_valid_q;
  assign speed_o.avg_speed = avg_q;

endmodule

// ===== hw/rtl/motor_speed_telemetry_averager.sv =====
`timescale 1ns / 1ps
// Top level of the motor speed telemetry averager.
// Depends on msta_pkg, msta_intf, msta_front, msta_fifo, msta_back.

// Feed the received reply text one character per transfer on char_i. In each
// newline-ended line the first "2A02" starts a sample: the next 8 hex digits
// (either case) form a 32-bit word sent low byte first, and at the 12th
// character after the marker the word is turned into a signed speed. A set
// top bit means negative, with magnitude 2^32 - word. The magnitude is scaled
// to rpm as floor(mag*6/10000); anything above speed_cutoff counts as
// standstill and enters the window as zero. The rpm goes into a WINDOW-deep
// moving window with a running sum and the result is floor(sum/WINDOW) with
// the sign of the current sample, delivered on speed_o. A non-hex digit drops
// the sample; a newline ends the line at any point. The block takes one
// character per cycle; char_i.ready drops only while the two-entry sample
// queue between parser and arithmetic is full, which happens only when
// speed_o is held off. Once its last character is taken, a sample's word
// goes through the queue, then the magnitude, rpm multiply, window update,
// average multiply and output register stages, all held while speed_o is
// stalled. Samples come at most once every 16 characters. cfg_i is always
// ready and sets speed_cutoff (reset 10000); write it only while no sample
// is in flight.
module motor_speed_telemetry_averager #(
  parameter int unsigned WINDOW = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msta_char_if.sink   char_i,
  msta_cfg_if.sink    cfg_i,
  msta_speed_if.source speed_o
);

  logic              accept;
  logic              fifo_full;
  logic              pop;
  msta_pkg::sample_t sample;
  msta_pkg::sample_t head;
  logic [15:0]       cutoff_q;

  // cutoff register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= msta_pkg::CUTOFF_RESET;
    end else if (cfg_i.valid) begin
      cutoff_q <= cfg_i.speed_cutoff;
    end
  end

  // a character is taken whenever a finished sample would have room
  assign char_i.ready = !fifo_full;
  assign accept       = char_i.valid && !fifo_full;

  msta_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_char_i (char_i.rx_char),
    .sample_o  (sample)
  );

  msta_fifo #(
    .DEPTH (msta_pkg::QUEUE_DEPTH),
    .WIDTH (32)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sample.valid),
    .data_i  (sample.word),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (head.valid),
    .data_o  (head.word)
  );

  msta_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .cutoff_i (cutoff_q),
    .speed_o  (speed_o)
  );

endmodule

// ===== hw/rtl/msta_checker.sv =====
`timescale 1ns / 1ps
// msta_checker: port-level checks of the telemetry averager, bound to the
// top level. Depends on motor_speed_telemetry_averager.
module msta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [16:0] out_speed_i
);

  // a pending result holds until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_speed_i))
    else $error("result changed while stalled");

  // magnitude never exceeds 65535, so -65536 cannot show up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_speed_i != 17'h10000)
    else $error("average out of range");

  // the pipeline is empty right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |=> !out_valid_i)
    else $error("result right after reset");

endmodule

bind motor_speed_telemetry_averager msta_checker u_msta_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (speed_o.valid),
  .out_ready_i (speed_o.ready),
  .out_speed_i (speed_o.avg_speed)
);

// ===== sim/msta_average_checker.sv =====
`timescale 1ns / 1ps
// msta_average_checker: watches the character, cutoff and speed channels of the
// telemetry averager, predicts each averaged speed and compares. Uses msta_pkg.
module msta_average_checker #(
  parameter int unsigned WINDOW = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               char_valid_i,
  input  logic               char_ready_i,
  input  logic [7:0]         rx_char_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [15:0]        cfg_cutoff_i,
  input  logic               speed_valid_i,
  input  logic               speed_ready_i,
  input  logic signed [16:0] avg_speed_i,
  output int                 mismatch_o,
  output int                 pending_o,
  output int                 predicted_o
);

  // predicted line parser and averaging window
  logic [15:0] cutoff;
  logic [2:0]  marker_hits;
  logic        in_sample;
  logic [3:0]  chars_seen;
  logic [31:0] speed_word;
  logic        digit_bad;
  logic [15:0] rpm_window [WINDOW];
  int unsigned slot;
  int unsigned rpm_sum;

  logic [16:0] expected_avg_q [$];
  int          mismatch_count = 0;
  int          predicted_count = 0;

  assign mismatch_o  = mismatch_count;
  assign predicted_o = predicted_count;

  task automatic report_mismatch(input string what);
    $display("%t ERROR: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic predict_from_char(input logic [7:0] c);
    int          pos;
    int          shift;
    logic [4:0]  nib;
    logic        neg;
    logic [31:0] mag;
    logic [63:0] rpm;
    logic [31:0] avg;
    if (in_sample) begin
      if (chars_seen < msta_pkg::LINE_LEN) begin
        chars_seen = chars_seen + 4'd1;
        if (chars_seen <= msta_pkg::HEX_DIGITS) begin
          pos   = int'(chars_seen) - 1;
          shift = 8 * (pos / 2) + ((pos % 2 == 1) ? 0 : 4);
          if (c >= "0" && c <= "9") nib = {1'b1, 4'(c - "0")};
          else if (c >= "A" && c <= "F") nib = {1'b1, 4'(c - "A" + 8'd10)};
          else if (c >= "a" && c <= "f") nib = {1'b1, 4'(c - "a" + 8'd10)};
          else nib = 5'd0;
          if (!nib[4]) digit_bad = 1'b1;
          else speed_word = speed_word | (32'(nib[3:0]) << shift);
        end
        if (chars_seen == msta_pkg::LINE_LEN && !digit_bad) begin
          neg = speed_word[31];
          mag = neg ? (~speed_word + 32'd1) : speed_word;
          rpm = (64'(mag) * 64'd6) / 64'd10000;
          if (rpm > 64'(cutoff)) rpm = 64'd0;
          slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;
          rpm_sum = rpm_sum - rpm_window[slot] + 32'(rpm[15:0]);
          rpm_window[slot] = rpm[15:0];
          avg = rpm_sum / WINDOW;
          if (neg) avg = ~avg + 32'd1;
          expected_avg_q.push_back(avg[16:0]);
          predicted_count++;
        end
      end
    end else begin
      if (c == msta_pkg::MARKER[marker_hits[1:0]]) marker_hits = marker_hits + 3'd1;
      else marker_hits = (c == msta_pkg::MARKER[0]) ? 3'd1 : 3'd0;
      if (marker_hits == msta_pkg::MARKER_LEN) begin
        marker_hits = 3'd0;
        in_sample   = 1'b1;
        chars_seen  = 4'd0;
        speed_word  = 32'd0;
        digit_bad   = 1'b0;
      end
    end
    if (c == msta_pkg::NEWLINE) begin
      marker_hits = 3'd0;
      in_sample   = 1'b0;
      chars_seen  = 4'd0;
      speed_word  = 32'd0;
      digit_bad   = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [16:0] want;
    if (!rst_ni) begin
      cutoff      = msta_pkg::CUTOFF_RESET;
      marker_hits = 3'd0;
      in_sample   = 1'b0;
      chars_seen  = 4'd0;
      speed_word  = 32'd0;
      digit_bad   = 1'b0;
      for (int i = 0; i < WINDOW; i++) rpm_window[i] = 16'd0;
      slot        = WINDOW - 1;
      rpm_sum     = 0;
      expected_avg_q.delete();
      pending_o   = 0;
    end else begin
      // results first: nothing sent at this edge can complete at this edge
      if (speed_valid_i && speed_ready_i) begin
        if (expected_avg_q.size() == 0) begin
          report_mismatch($sformatf("unexpected speed transfer %0d", avg_speed_i));
        end else begin
          want = expected_avg_q.pop_front();
          if (avg_speed_i !== want)
            report_mismatch($sformatf("avg_speed %0d, expected %0d",
                                      avg_speed_i, $signed(want)));
        end
      end
      if (cfg_valid_i && cfg_ready_i) cutoff = cfg_cutoff_i;
      if (char_valid_i && char_ready_i) predict_from_char(rx_char_i);
      pending_o = expected_avg_q.size();
    end
  end

endmodule

// ===== sim/motor_speed_telemetry_averager_test.sv =====
`timescale 1ns / 1ps
// Testbench top of the motor speed telemetry averager: clock, reset, character
// and cutoff stimulus, output stalls, verdict. Uses msta_pkg, msta_intf,
// msta_average_checker and the averager RTL.
module motor_speed_telemetry_averager_test;

  localparam int unsigned WINDOW      = 10;
  localparam int          HOLD_CYCLES = 1000;  // long output hold-off
  localparam int          QUIET_LIMIT = 5000;  // cycles without any transfer
  localparam int          TOTAL_CHARS = 1550;
  localparam int          PHASE_CHARS = 250;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #2 clk_i = ~clk_i;

  msta_char_if  char_if ();
  msta_cfg_if   cfg_if ();
  msta_speed_if speed_if ();

  motor_speed_telemetry_averager #(
    .WINDOW (WINDOW)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .cfg_i   (cfg_if),
    .speed_o (speed_if)
  );

  int mismatches;
  int pending;
  int predicted;

  msta_average_checker #(
    .WINDOW (WINDOW)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .char_valid_i  (char_if.valid),
    .char_ready_i  (char_if.ready),
    .rx_char_i     (char_if.rx_char),
    .cfg_valid_i   (cfg_if.valid),
    .cfg_ready_i   (cfg_if.ready),
    .cfg_cutoff_i  (cfg_if.speed_cutoff),
    .speed_valid_i (speed_if.valid),
    .speed_ready_i (speed_if.ready),
    .avg_speed_i   (speed_if.avg_speed),
    .mismatch_o    (mismatches),
    .pending_o     (pending),
    .predicted_o   (predicted)
  );

  // Flags shared by the stimulus and the output-side process, then stimulus state
  bit          idle_on  = 1'b1;  // random gaps on both sides
  bit          hold_req = 1'b0;  // one long hold-off on the speed channel
  int unsigned cur_cutoff = msta_pkg::CUTOFF_RESET;
  int          sent_chars = 0;
  logic [7:0]  line_q [$];       // characters of the line being built

  // ---------------------------------------------------------------------------
  // Watchdog: a run that stops moving is a failure.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((char_if.valid && char_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (speed_if.valid && speed_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("motor_speed_telemetry_averager_test NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Speed channel receiver. Ready is random in bursts while idle_on is set and
  // always high otherwise. A hold request drops ready for HOLD_CYCLES so that
  // the sample queue fills and char_i.ready has to go low.
  // ---------------------------------------------------------------------------
  initial begin
    speed_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        speed_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        speed_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        speed_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Character helpers
  // ---------------------------------------------------------------------------

  // any byte but newline
  function automatic logic [7:0] noise_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 254));
    if (v >= msta_pkg::NEWLINE) v = v + 8'd1;
    return v;
  endfunction

  // neither a hex digit nor a newline
  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(11, 47));
      2:       return 8'($urandom_range(58, 64));
      3:       return 8'($urandom_range(71, 96));
      default: return 8'($urandom_range(103, 255));
    endcase
  endfunction

  // digit letters come in either case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] base;
    if (nib < 4'd10) return 8'("0") + 8'(nib);
    base = $urandom_range(0, 1) ? 8'("A") : 8'("a");
    return base + 8'(nib) - 8'd10;
  endfunction

  // marker characters now and then, so that repeat markers show up
  function automatic logic [7:0] filler_char();
    if ($urandom_range(0, 3) == 0) return msta_pkg::MARKER[$urandom_range(0, 3)];
    return noise_char();
  endfunction

  // Speed word: mostly rpm around the current cutoff or across the whole rpm
  // range, either sign; some fully random words and the corner values.
  function automatic logic [31:0] pick_word();
    int unsigned rpm;
    logic [63:0] mag;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h8000_0000;
          3:       return 32'hFFFF_FFFF;
          // magnitude right at the edge where rpm no longer fits 16 bits
          default: return msta_pkg::RPM_BIG_MAG - 32'($urandom_range(0, 1));
        endcase
      end
      default: begin
        rpm = $urandom_range(0, 1) ? $urandom_range(0, 70000)
                                   : $urandom_range(0, cur_cutoff + 20);
        mag = 64'(rpm) * 64'd10000 / 64'd6 + 64'($urandom_range(0, 1666));
        return $urandom_range(0, 1) ? mag[31:0] : (~mag[31:0] + 32'd1);
      end
    endcase
  endfunction

  function automatic void push_marker();
    for (int i = 0; i < int'(msta_pkg::MARKER_LEN); i++) begin
      line_q.push_back(msta_pkg::MARKER[i]);
    end
  endfunction

  // Line with a sample: noise, maybe one to three leading marker characters, the
  // marker, eight digits (one spoiled when bad_digit), three more characters,
  // then either the newline as 12th character or more text that the parser ignores.
  task automatic build_sample_line(input bit bad_digit);
    logic [31:0] word;
    int          spoil_at;
    word     = pick_word();
    spoil_at = bad_digit ? $urandom_range(0, 7) : -1;
    repeat ($urandom_range(0, 4)) line_q.push_back(noise_char());
    case ($urandom_range(0, 5))
      0: line_q = {line_q, msta_pkg::MARKER[0], msta_pkg::MARKER[1]};
      1: line_q = {line_q, msta_pkg::MARKER[0], msta_pkg::MARKER[1], msta_pkg::MARKER[2]};
      2: line_q.push_back(msta_pkg::MARKER[0]);
      default: ;
    endcase
    push_marker();
    for (int k = 0; k < 8; k++) begin
      // first pair of digits is the low byte, high nibble first
      line_q.push_back((k == spoil_at) ? non_hex_char()
                                       : hex_char(word[8 * (k / 2) + ((k % 2) ? 0 : 4) +: 4]));
    end
    repeat (3) line_q.push_back(filler_char());
    if ($urandom_range(0, 2) == 0) begin
      line_q.push_back(msta_pkg::NEWLINE);
    end else begin
      line_q.push_back(filler_char());
      if ($urandom_range(0, 3) == 0) push_marker();
      repeat ($urandom_range(0, 6)) line_q.push_back(filler_char());
      line_q.push_back(msta_pkg::NEWLINE);
    end
  endtask

  // Line cut short by the newline, with or without a marker
  task automatic build_short_line();
    if ($urandom_range(0, 1)) push_marker();
    repeat ($urandom_range(0, 10))
      line_q.push_back($urandom_range(0, 3) ? hex_char(4'($urandom())) : noise_char());
    line_q.push_back(msta_pkg::NEWLINE);
  endtask

  // ---------------------------------------------------------------------------
  // Transfers
  // ---------------------------------------------------------------------------

  // valid stays high from one character to the next unless a gap is taken
  task automatic send_char(input logic [7:0] c);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      char_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    char_if.valid   <= 1'b1;
    char_if.rx_char <= c;
    do @(posedge clk_i); while (char_if.ready !== 1'b1);
    sent_chars++;
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_char(line_q.pop_front());
  endtask

  // Wait for every predicted speed, then for the pipeline to run dry
  task automatic drain();
    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_cutoff(input logic [15:0] value);
    cfg_if.valid        <= 1'b1;
    cfg_if.speed_cutoff <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    cur_cutoff = value;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          pick;
    int          phase_start;
    logic [15:0] cutoff_val;

    rst_ni              <= 1'b0;
    char_if.valid       <= 1'b0;
    char_if.rx_char     <= 8'd0;
    cfg_if.valid        <= 1'b0;
    cfg_if.speed_cutoff <= 16'd0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset cutoff: the byte extremes ahead of the marker, a sample
    // of 1000000 (600 rpm) closed by the newline as 12th character, then a
    // short line that both spoils a digit and ends early.
    line_q = {8'h00, 8'hFF, msta_pkg::MARKER[0], msta_pkg::MARKER[1],
              msta_pkg::MARKER[2], msta_pkg::MARKER[3],
              8'("4"), 8'("0"), 8'("4"), 8'("2"), 8'("0"), 8'("f"), 8'("0"), 8'("0"),
              8'("x"), 8'("y"), 8'("z"), msta_pkg::NEWLINE,
              msta_pkg::MARKER[0], msta_pkg::MARKER[1], msta_pkg::MARKER[2],
              msta_pkg::MARKER[3], 8'("0"), 8'("g"), msta_pkg::NEWLINE};
    send_line();

    // Random phases, each under its own cutoff. Phase 1 carries the long
    // output hold-off; the last phase runs without gaps until enough
    // characters have gone through.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0:       cutoff_val = 16'd0;
        1:       cutoff_val = 16'hFFFF;
        2:       cutoff_val = 16'($urandom_range(1, 3000));
        3:       cutoff_val = msta_pkg::CUTOFF_RESET;
        4:       cutoff_val = 16'($urandom());
        default: cutoff_val = 16'($urandom_range(100, 20000));
      endcase
      write_cutoff(cutoff_val);
      if (phase == 1) hold_req = 1'b1;
      if (phase == 5) idle_on = 1'b0;
      phase_start = sent_chars;
      while ((phase < 5) ? (sent_chars - phase_start < PHASE_CHARS)
                         : (sent_chars < TOTAL_CHARS)) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          build_sample_line(1'b0);
        end else if (pick < 77) begin
          build_sample_line(1'b1);
        end else if (pick < 90) begin
          build_short_line();
        end else begin
          // raw bytes, newlines included
          repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom()));
          line_q.push_back(msta_pkg::NEWLINE);
        end
        send_line();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("motor_speed_telemetry_averager_test OK");
    end else begin
      $display("motor_speed_telemetry_averager_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== motor_speed_telemetry_averager.f =====
hw/rtl/msta_pkg.sv
hw/rtl/msta_intf.sv
hw/rtl/msta_front.sv
hw/rtl/msta_fifo.sv
hw/rtl/msta_back.sv
hw/rtl/motor_speed_telemetry_averager.sv
hw/rtl/msta_checker.sv
sim/msta_average_checker.sv
sim/motor_speed_telemetry_averager_test.sv
